// ===== rtl/i2da_pkg.sv =====
package i2da_pkg;

    localparam int VALUE_W   = 31;
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = 10;
    localparam int BCD_W     = DIGIT_W * DIGITS;
    localparam int CNT_W     = $clog2(VALUE_W + 1);
    localparam int LEFT_W    = $clog2(DIGITS + 1);
    localparam int CHAR_W    = 6;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [DIGIT_W-1:0] DABBLE_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

    typedef enum logic [1:0] {
        CONV_IDLE,
        CONV_SHIFT,
        CONV_DONE
    } conv_state_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SKIP,
        EMIT_SEND
    } emit_state_t;

    // packed bcd digits handed from the converter to the emitter
    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] bcd;
    } i2da_bcd_t;

endpackage

// ===== rtl/i2da_dabble.sv =====
module i2da_dabble (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [i2da_pkg::VALUE_W-1:0]      in_value,
    output i2da_pkg::i2da_bcd_t               bcd_out,
    input  logic                              bcd_ready
);
    import i2da_pkg::*;

    conv_state_t           state_reg, state_next;
    logic [VALUE_W-1:0]    bin_reg, bin_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [BCD_W-1:0]      corrected;
    logic [DIGIT_W-1:0]    dig;

    // add-3 correction on every digit before the next shift
    always_comb begin
        corrected = '0;
        dig       = '0;
        for (int i = 0; i < DIGITS; i++) begin
            dig = bcd_reg[i*DIGIT_W +: DIGIT_W];
            corrected[i*DIGIT_W +: DIGIT_W] = (dig >= DABBLE_MIN) ? dig + DABBLE_ADD : dig;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CONV_IDLE:  if (in_valid) state_next = CONV_SHIFT;
            CONV_SHIFT: if (cnt_reg == CNT_W'(1)) state_next = CONV_DONE;
            CONV_DONE:  if (bcd_ready) state_next = CONV_IDLE;
            default:    state_next = CONV_IDLE;
        endcase
    end

    always_comb begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            CONV_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    bin_next = in_value;
                    bcd_next = '0;
                    cnt_next = CNT_W'(VALUE_W);
                end
            end
            CONV_SHIFT: begin
                bcd_next = {corrected[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign bcd_out.valid = (state_reg == CONV_DONE);
    assign bcd_out.bcd   = bcd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CONV_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    a_shift_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == CONV_SHIFT |-> cnt_reg != '0)
        else $error("shift state with exhausted bit count");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> state_reg == CONV_SHIFT && cnt_reg == CNT_W'(VALUE_W))
        else $error("accepted value did not start conversion");

endmodule

// ===== rtl/i2da_emit.sv =====
module i2da_emit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  i2da_pkg::i2da_bcd_t               bcd_in,
    output logic                              bcd_ready,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [i2da_pkg::CHAR_W-1:0]       out_char,
    output logic                              out_last
);
    import i2da_pkg::*;

    emit_state_t           state_reg, state_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [LEFT_W-1:0]     left_reg, left_next;
    logic [DIGIT_W-1:0]    top_digit;

    assign top_digit = bcd_reg[BCD_W-1 -: DIGIT_W];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            EMIT_IDLE: if (bcd_in.valid) state_next = EMIT_SKIP;
            EMIT_SKIP: if (top_digit != '0 || left_reg == LEFT_W'(1)) state_next = EMIT_SEND;
            EMIT_SEND: if (out_ready && left_reg == LEFT_W'(1)) state_next = EMIT_IDLE;
            default:   state_next = EMIT_IDLE;
        endcase
    end

    always_comb begin
        bcd_next  = bcd_reg;
        left_next = left_reg;
        bcd_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            EMIT_IDLE: begin
                bcd_ready = 1'b1;
                if (bcd_in.valid) begin
                    bcd_next  = bcd_in.bcd;
                    left_next = LEFT_W'(DIGITS);
                end
            end
            EMIT_SKIP: begin
                // drop leading zeros, always keeping the units digit
                if (top_digit == '0 && left_reg != LEFT_W'(1)) begin
                    bcd_next  = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    left_next = left_reg - LEFT_W'(1);
                end
            end
            EMIT_SEND: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    bcd_next  = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    left_next = left_reg - LEFT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign out_char = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
    assign out_last = (left_reg == LEFT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EMIT_IDLE;
            left_reg  <= '0;
        end else begin
            state_reg <= state_next;
            left_reg  <= left_next;
        end
        bcd_reg <= bcd_next;
    end

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> top_digit <= DIGIT_MAX && left_reg != '0
                      && left_reg <= LEFT_W'(DIGITS))
        else $error("emitted digit or digit count out of range");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_ready && out_last |=> state_reg == EMIT_IDLE)
        else $error("emitter kept sending after the last character");

endmodule

// ===== rtl/integer_to_decimal_ascii_top.sv =====
// Prints a non-negative 31-bit integer as decimal ASCII characters, most
// significant digit first, without leading zeros; zero gives a single '0'.
// Each character is one output transaction and the final one carries tlast.
// A value is converted bit-serially by a shift-and-add-3 converter, one
// shift per value bit after it is accepted. The finished digits are then
// handed to the character stage, and a new value is taken only once that
// stage has taken the digits of the last one. The character stage drops
// each leading zero digit, finds the first digit it sends and then sends
// one character per accepted transfer, while the converter already works
// on the next value. The first character is offered once the digits are
// handed off and the leading zero digits are dropped.
module integer_to_decimal_ascii_top (
    input  logic                              aclk,
    input  logic                              aresetn,

    // input transactions
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [i2da_pkg::S_TDATA_W-1:0]    s_tdata,   // [30:0] value, [31] zero

    // output transactions, one per character
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [i2da_pkg::M_TDATA_W-1:0]    m_tdata,   // [5:0] ascii_char, [7:6] zero
    output logic                              m_tlast    // last_char
);
    import i2da_pkg::*;

    i2da_bcd_t             bcd_link;   // finished digits, converter to emitter
    logic                  bcd_ready;
    logic [CHAR_W-1:0]     char_out;

    // bit-serial binary to bcd converter
    i2da_dabble u_dabble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VALUE_W-1:0]),
        .bcd_out   (bcd_link),
        .bcd_ready (bcd_ready)
    );

    // digit shift register and output stage
    i2da_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .bcd_in    (bcd_link),
        .bcd_ready (bcd_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (char_out),
        .out_last  (m_tlast)
    );

    // pad the character to a whole byte
    assign m_tdata = {{(M_TDATA_W-CHAR_W){1'b0}}, char_out};

endmodule
